### sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, sampled on clk, off while arst_n is low
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### sv/pmid_pkg.sv
package pmid_pkg;

	// field widths
	localparam int POS_W    = 31;
	localparam int DIFF_W   = 32;
	localparam int MAG_W    = 31;
	localparam int BOX_W    = 31;
	localparam int RECIP_W  = 32;
	localparam int PROD_W   = MAG_W + RECIP_W;
	localparam int IMG_W    = 16;
	localparam int SHIFT_W  = IMG_W + BOX_W;
	localparam int SQ_W     = 2 * MAG_W;
	localparam int SUM_W    = 64;
	localparam int MODE_W   = 2;
	localparam int NUM_AXES = 3;

	// stream widths
	localparam int IN_TDATA_W  = 192;
	localparam int OUT_TDATA_W = NUM_AXES * DIFF_W + SUM_W;
	localparam int OUT_TUSER_W = 1;

	// config port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;

	localparam logic [CFG_IDX_W-1:0] REG_BOX_X     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_Y     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_Z     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RECIP_X   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RECIP_Y   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_RECIP_Z   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SQ_CUTOFF = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_MODE      = 3'd7;

	// mode bits
	localparam int MODE_WRAP_BIT = 0;
	localparam int MODE_CUT_BIT  = 1;

	// reset values
	localparam logic [BOX_W-1:0]   BOX_RST   = 31'd65536;
	localparam logic [RECIP_W-1:0] RECIP_RST = 32'hFFFF_FFFF;

	// rounding constant for the image count, one half in Q16.48
	localparam int RND_BIT = 47;

	localparam int NUM_STAGES = 10;

	typedef logic signed [POS_W-1:0]  pos_t;
	typedef logic signed [DIFF_W-1:0] diff_t;
	typedef logic [MAG_W-1:0]         mag_t;
	typedef logic [PROD_W-1:0]        prod_t;
	typedef logic [IMG_W-1:0]         img_t;
	typedef logic [SHIFT_W-1:0]       shift_t;
	typedef logic [SQ_W-1:0]          sq_t;
	typedef logic [SUM_W-1:0]         sum_t;

endpackage

### sv/pair_min_image_distance_top.sv
// Minimum-image pair distance. Each input transfer carries two atom positions
// (signed Q15.16) and yields one output transfer holding the difference vector
// second minus first (signed Q16.16), its squared length (unsigned Q32.32) and
// a within-cutoff flag in tuser. With mode bit0 set every axis is wrapped as
// d - box * round(d * recip_box), ties away from zero, and saturated to
// +/-(2^31 - 1); software writes both box and its Q0.32 reciprocal. With mode
// bit1 set the flag is sq_distance < sq_cutoff, otherwise it is 1. The block
// takes one item per clock while the output is not stalled, in a ten-stage
// pipeline (difference, magnitude, reciprocal multiply, rounding, box
// multiply, wrap, magnitude, square, sum, cutoff compare), one 32x32 class
// multiplier stage per multiply. A stalled output holds only the full stages
// next to it and bubbles get squeezed out. Configuration uses the cfg channel,
// always ready; the user writes only while no item is in flight (unenforced).
module pair_min_image_distance_top (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration write channel
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [pmid_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pmid_pkg::CFG_DATA_W-1:0]     cfg_data,
	// input stream
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// first_x, first_y, first_z, second_x, second_y, second_z (31 bits each),
	// upper 6 bits zero
	input  logic [pmid_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	// output stream
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// diff_x, diff_y, diff_z (32 bits each), sq_distance (64 bits)
	output logic [pmid_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	// within_cutoff
	output logic [pmid_pkg::OUT_TUSER_W-1:0]    m_axis_tuser
);

	import pmid_pkg::*;

	// saturation bounds on the wide wrapped value
	localparam int WR_W = SHIFT_W + 2;
	localparam logic signed [WR_W-1:0] WR_MAX = WR_W'((64'd1 << (DIFF_W - 1)) - 64'd1);
	localparam logic signed [WR_W-1:0] WR_MIN = -WR_MAX;

	// ---------------------------------------------------------------------
	// configuration registers
	// ---------------------------------------------------------------------
	logic [BOX_W-1:0]   box_q   [NUM_AXES];
	logic [RECIP_W-1:0] recip_q [NUM_AXES];
	sum_t               cutoff_q;
	logic [MODE_W-1:0]  mode_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				box_q[a]   <= BOX_RST;
				recip_q[a] <= RECIP_RST;
			end
			cutoff_q <= '0;
			mode_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			// every 3-bit index names a register, so the default arm is never taken
			unique case (cfg_index)
				REG_BOX_X:     box_q[0]   <= cfg_data[BOX_W-1:0];
				REG_BOX_Y:     box_q[1]   <= cfg_data[BOX_W-1:0];
				REG_BOX_Z:     box_q[2]   <= cfg_data[BOX_W-1:0];
				REG_RECIP_X:   recip_q[0] <= cfg_data[RECIP_W-1:0];
				REG_RECIP_Y:   recip_q[1] <= cfg_data[RECIP_W-1:0];
				REG_RECIP_Z:   recip_q[2] <= cfg_data[RECIP_W-1:0];
				REG_SQ_CUTOFF: cutoff_q   <= cfg_data[SUM_W-1:0];
				REG_MODE:      mode_q     <= cfg_data[MODE_W-1:0];
				default:       ;
			endcase
		end
	end

	// ---------------------------------------------------------------------
	// pipeline flow control
	// a stage moves when it is empty or the stage after it moves, so the
	// last stage is the output register and bubbles get squeezed out
	// ---------------------------------------------------------------------
	logic [NUM_STAGES:1]   vld_q;
	logic [NUM_STAGES+1:1] en;

	always_comb begin
		en[NUM_STAGES+1] = m_axis_tready;
		for (int k = NUM_STAGES; k >= 1; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	assign s_axis_tready = en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[1]) begin
				vld_q[1] <= s_axis_tvalid;
			end
			for (int k = 2; k <= NUM_STAGES; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	// ---------------------------------------------------------------------
	// input unpacking
	// ---------------------------------------------------------------------
	pos_t first_pos  [NUM_AXES];
	pos_t second_pos [NUM_AXES];

	always_comb begin
		for (int a = 0; a < NUM_AXES; a++) begin
			first_pos[a]  = s_axis_tdata[a*POS_W +: POS_W];
			second_pos[a] = s_axis_tdata[(a+NUM_AXES)*POS_W +: POS_W];
		end
	end

	// ---------------------------------------------------------------------
	// stage 1: raw difference, exact in Q16.16
	// ---------------------------------------------------------------------
	diff_t d_s1 [NUM_AXES];

	always_ff @(posedge clk) begin
		if (en[1]) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				d_s1[a] <= DIFF_W'(second_pos[a]) - DIFF_W'(first_pos[a]);
			end
		end
	end

	// ---------------------------------------------------------------------
	// stage 2: sign and magnitude
	// ---------------------------------------------------------------------
	diff_t d_s2   [NUM_AXES];
	mag_t  mag_s2 [NUM_AXES];
	logic  neg_s2 [NUM_AXES];

	always_ff @(posedge clk) begin
		if (en[2]) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				d_s2[a]   <= d_s1[a];
				neg_s2[a] <= d_s1[a][DIFF_W-1];
				mag_s2[a] <= d_s1[a][DIFF_W-1] ? MAG_W'(-d_s1[a]) : MAG_W'(d_s1[a]);
			end
		end
	end

	// ---------------------------------------------------------------------
	// stage 3: |d| * recip_box in Q15.48, later rounded in Q16.48
	// ---------------------------------------------------------------------
	diff_t d_s3    [NUM_AXES];
	logic  neg_s3  [NUM_AXES];
	prod_t prod_s3 [NUM_AXES];

	always_ff @(posedge clk) begin
		if (en[3]) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				d_s3[a]    <= d_s2[a];
				neg_s3[a]  <= neg_s2[a];
				prod_s3[a] <= PROD_W'(mag_s2[a]) * PROD_W'(recip_q[a]);
			end
		end
	end

	// ---------------------------------------------------------------------
	// stage 4: image count, rounded half away from zero on the magnitude
	// ---------------------------------------------------------------------
	diff_t            d_s4   [NUM_AXES];
	logic             neg_s4 [NUM_AXES];
	img_t             img_s4 [NUM_AXES];
	logic [PROD_W:0]  rnd    [NUM_AXES];

	always_comb begin
		for (int a = 0; a < NUM_AXES; a++) begin
			rnd[a] = {1'b0, prod_s3[a]} + ((PROD_W+1)'(1) << RND_BIT);
		end
	end

	always_ff @(posedge clk) begin
		if (en[4]) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				d_s4[a]   <= d_s3[a];
				neg_s4[a] <= neg_s3[a];
				img_s4[a] <= rnd[a][PROD_W -: IMG_W];
			end
		end
	end

	// ---------------------------------------------------------------------
	// stage 5: image count times box length
	// ---------------------------------------------------------------------
	diff_t  d_s5     [NUM_AXES];
	logic   neg_s5   [NUM_AXES];
	shift_t shift_s5 [NUM_AXES];

	always_ff @(posedge clk) begin
		if (en[5]) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				d_s5[a]     <= d_s4[a];
				neg_s5[a]   <= neg_s4[a];
				shift_s5[a] <= SHIFT_W'(img_s4[a]) * SHIFT_W'(box_q[a]);
			end
		end
	end

	// ---------------------------------------------------------------------
	// stage 6: wrap toward zero, saturate, pick wrapped or raw
	// ---------------------------------------------------------------------
	diff_t                  diff_s6 [NUM_AXES];
	logic signed [WR_W-1:0] wr      [NUM_AXES];
	diff_t                  wr_sat  [NUM_AXES];

	always_comb begin
		for (int a = 0; a < NUM_AXES; a++) begin
			if (neg_s5[a]) begin
				wr[a] = WR_W'(d_s5[a]) + $signed({2'b00, shift_s5[a]});
			end else begin
				wr[a] = WR_W'(d_s5[a]) - $signed({2'b00, shift_s5[a]});
			end
			priority if (wr[a] > WR_MAX) begin
				wr_sat[a] = DIFF_W'(WR_MAX);
			end else if (wr[a] < WR_MIN) begin
				wr_sat[a] = DIFF_W'(WR_MIN);
			end else begin
				wr_sat[a] = DIFF_W'(wr[a]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[6]) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				diff_s6[a] <= mode_q[MODE_WRAP_BIT] ? wr_sat[a] : d_s5[a];
			end
		end
	end

	// ---------------------------------------------------------------------
	// stage 7: magnitude of the final component
	// ---------------------------------------------------------------------
	diff_t diff_s7 [NUM_AXES];
	mag_t  mag_s7  [NUM_AXES];

	always_ff @(posedge clk) begin
		if (en[7]) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				diff_s7[a] <= diff_s6[a];
				mag_s7[a]  <= diff_s6[a][DIFF_W-1] ? MAG_W'(-diff_s6[a]) : MAG_W'(diff_s6[a]);
			end
		end
	end

	// ---------------------------------------------------------------------
	// stage 8: squares, exact in Q30.32 ahead of the sum in Q32.32
	// ---------------------------------------------------------------------
	diff_t diff_s8 [NUM_AXES];
	sq_t   sq_s8   [NUM_AXES];

	always_ff @(posedge clk) begin
		if (en[8]) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				diff_s8[a] <= diff_s7[a];
				sq_s8[a]   <= SQ_W'(mag_s7[a]) * SQ_W'(mag_s7[a]);
			end
		end
	end

	// ---------------------------------------------------------------------
	// stage 9: sum of squares, cannot overflow 64 bits
	// ---------------------------------------------------------------------
	diff_t diff_s9 [NUM_AXES];
	sum_t  sum_s9;

	always_ff @(posedge clk) begin
		if (en[9]) begin
			diff_s9 <= diff_s8;
			sum_s9  <= SUM_W'(sq_s8[0]) + SUM_W'(sq_s8[1]) + SUM_W'(sq_s8[2]);
		end
	end

	// ---------------------------------------------------------------------
	// stage 10: cutoff compare, output register
	// ---------------------------------------------------------------------
	diff_t diff_s10 [NUM_AXES];
	sum_t  sum_s10;
	logic  within_s10;

	always_ff @(posedge clk) begin
		if (en[10]) begin
			diff_s10   <= diff_s9;
			sum_s10    <= sum_s9;
			within_s10 <= !mode_q[MODE_CUT_BIT] || (sum_s9 < cutoff_q);
		end
	end

	// output packing
	always_comb begin
		for (int a = 0; a < NUM_AXES; a++) begin
			m_axis_tdata[a*DIFF_W +: DIFF_W] = diff_s10[a];
		end
		m_axis_tdata[NUM_AXES*DIFF_W +: SUM_W] = sum_s10;
	end

	assign m_axis_tuser  = OUT_TUSER_W'(within_s10);
	assign m_axis_tvalid = vld_q[NUM_STAGES];

endmodule

### sv/pmid_checker.sv
`include "assert_macros.svh"

module pmid_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	input  logic                                cfg_ready,
	input  logic [pmid_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pmid_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	input  logic [pmid_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	input  logic [pmid_pkg::OUT_TUSER_W-1:0]    m_axis_tuser
);

	import pmid_pkg::*;

	localparam logic [DIFF_W-1:0] DIFF_MOST_NEG = {1'b1, {(DIFF_W-1){1'b0}}};

	// shadow of the cutoff enable as written over the cfg port
	logic cut_en_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cut_en_q <= 1'b0;
		end else if (cfg_valid && cfg_ready && (cfg_index == REG_MODE)) begin
			cut_en_q <= cfg_data[MODE_CUT_BIT];
		end
	end

	// a stalled result holds
	`ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

	// with the cutoff test off every result is flagged inside
	`ASSERT_IMPL(a_cut_off_flag, m_axis_tvalid && !cut_en_q, m_axis_tuser[0])

	// saturation never reaches the most negative code
	`ASSERT_IMPL(a_no_most_neg, m_axis_tvalid, (m_axis_tdata[0 +: DIFF_W] != DIFF_MOST_NEG) && (m_axis_tdata[DIFF_W +: DIFF_W] != DIFF_MOST_NEG) && (m_axis_tdata[2*DIFF_W +: DIFF_W] != DIFF_MOST_NEG))

	// zero length only for the zero vector
	`ASSERT_IMPL(a_zero_dist, m_axis_tvalid && (m_axis_tdata[NUM_AXES*DIFF_W +: SUM_W] == '0), m_axis_tdata[0 +: NUM_AXES*DIFF_W] == '0)

endmodule

bind pair_min_image_distance_top pmid_checker u_pmid_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.cfg_valid     (cfg_valid),
	.cfg_ready     (cfg_ready),
	.cfg_index     (cfg_index),
	.cfg_data      (cfg_data),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

### test/image_distance_checker.sv
module image_distance_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	input  logic                                cfg_ready,
	input  logic [pmid_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pmid_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                s_axis_tvalid,
	input  logic                                s_axis_tready,
	// first_x, first_y, first_z, second_x, second_y, second_z, zero fill
	input  logic [pmid_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	input  logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// diff_x, diff_y, diff_z, sq_distance
	input  logic [pmid_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	// within_cutoff
	input  logic [pmid_pkg::OUT_TUSER_W-1:0]    m_axis_tuser,
	output int                                  mismatches,
	output int                                  outstanding
);
	import pmid_pkg::*;

	localparam longint DIFF_LIM = 64'sd2147483647;

	typedef struct {
		diff_t dx;
		diff_t dy;
		diff_t dz;
		sum_t  sq;
		logic  near;
	} separation_t;

	separation_t            expected_separations[$];
	logic [BOX_W-1:0]       box_len[NUM_AXES];
	logic [RECIP_W-1:0]     recip_len[NUM_AXES];
	logic [SUM_W-1:0]       cutoff_sq;
	logic [MODE_W-1:0]      mode_bits;
	int                     err_count = 0;
	int                     pending_count = 0;

	assign mismatches  = err_count;
	assign outstanding = pending_count;

	// minimum image fold of one axis, ties away from zero, clamped to the diff range
	function automatic longint fold_axis(longint d, logic [BOX_W-1:0] box,
			logic [RECIP_W-1:0] recip);
		logic [63:0] mag;
		logic [63:0] scaled;
		longint      images;
		longint      r;
		mag    = (d < 0) ? -d : d;
		scaled = mag * recip + (64'd1 << RND_BIT);
		images = longint'(scaled >> (RND_BIT + 1));
		r      = (d < 0) ? d + images * longint'(box) : d - images * longint'(box);
		if (r > DIFF_LIM)
			r = DIFF_LIM;
		if (r < -DIFF_LIM)
			r = -DIFF_LIM;
		return r;
	endfunction

	function automatic separation_t predict_separation(logic [IN_TDATA_W-1:0] word);
		longint      d[NUM_AXES];
		logic [63:0] mag;
		logic [63:0] total;
		separation_t s;
		total = '0;
		for (int m = 0; m < NUM_AXES; m++) begin
			d[m] = longint'($signed(word[POS_W*(NUM_AXES+m) +: POS_W]))
				- longint'($signed(word[POS_W*m +: POS_W]));
			if (mode_bits[MODE_WRAP_BIT])
				d[m] = fold_axis(d[m], box_len[m], recip_len[m]);
			mag   = (d[m] < 0) ? -d[m] : d[m];
			total = total + mag * mag;
		end
		s.dx   = d[0][DIFF_W-1:0];
		s.dy   = d[1][DIFF_W-1:0];
		s.dz   = d[2][DIFF_W-1:0];
		s.sq   = total;
		s.near = !mode_bits[MODE_CUT_BIT] || (total < cutoff_sq);
		return s;
	endfunction

	task automatic compare_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			err_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		separation_t s;
		if (!arst_n) begin
			for (int m = 0; m < NUM_AXES; m++) begin
				box_len[m]   = BOX_RST;
				recip_len[m] = RECIP_RST;
			end
			cutoff_sq = '0;
			mode_bits = '0;
		end else begin
			// results first: nothing accepted this edge can already be on the output
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_separations.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %h %h",
						$time, m_axis_tdata, m_axis_tuser);
					err_count++;
				end else begin
					s = expected_separations.pop_front();
					pending_count--;
					// diffs compared as raw 32-bit codes
					compare_field("diff_x", $unsigned(s.dx), m_axis_tdata[0 +: DIFF_W]);
					compare_field("diff_y", $unsigned(s.dy), m_axis_tdata[DIFF_W +: DIFF_W]);
					compare_field("diff_z", $unsigned(s.dz),
						m_axis_tdata[2*DIFF_W +: DIFF_W]);
					compare_field("sq_distance", s.sq, m_axis_tdata[3*DIFF_W +: SUM_W]);
					compare_field("within_cutoff", s.near, m_axis_tuser[0]);
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				expected_separations.push_back(predict_separation(s_axis_tdata));
				pending_count++;
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_BOX_X:     box_len[0]   = cfg_data[BOX_W-1:0];
					REG_BOX_Y:     box_len[1]   = cfg_data[BOX_W-1:0];
					REG_BOX_Z:     box_len[2]   = cfg_data[BOX_W-1:0];
					REG_RECIP_X:   recip_len[0] = cfg_data[RECIP_W-1:0];
					REG_RECIP_Y:   recip_len[1] = cfg_data[RECIP_W-1:0];
					REG_RECIP_Z:   recip_len[2] = cfg_data[RECIP_W-1:0];
					REG_SQ_CUTOFF: cutoff_sq    = cfg_data[SUM_W-1:0];
					REG_MODE:      mode_bits    = cfg_data[MODE_W-1:0];
					default: ;
				endcase
			end
		end
	end

endmodule

### test/pair_min_image_distance_top_tb.sv
module pair_min_image_distance_top_tb;
	import pmid_pkg::*;

	// mode register settings
	localparam logic [MODE_W-1:0] MODE_PLAIN = 2'd0;
	localparam logic [MODE_W-1:0] MODE_WRAP  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_CUT   = 2'd2;
	localparam logic [MODE_W-1:0] MODE_BOTH  = 2'd3;

	localparam longint FIX_ONE   = 65536;          // 1.0 in Q15.16
	localparam longint BOX_MAX   = 64'h7FFF_FFFF;
	localparam longint RECIP_MAX = 64'hFFFF_FFFF;
	localparam longint SPAN_MAX  = 64'h3FFF_FFFF;
	localparam pos_t   POS_MAX   = {1'b0, {(POS_W-1){1'b1}}};
	localparam pos_t   POS_MIN   = {1'b1, {(POS_W-1){1'b0}}};

	localparam int RANDOM_PHASES   = 6;
	localparam int ITEMS_PER_PHASE = 92;
	localparam int TAIL_CYCLES     = 2 * NUM_STAGES + 4;
	localparam int STALL_LIMIT     = 2000;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       cfg_valid = 1'b0;
	logic                       cfg_ready;
	logic [CFG_IDX_W-1:0]       cfg_index = '0;
	logic [CFG_DATA_W-1:0]      cfg_data = '0;
	logic                       s_axis_tvalid = 1'b0;
	logic                       s_axis_tready;
	logic [IN_TDATA_W-1:0]      s_axis_tdata = '0;
	logic                       m_axis_tvalid;
	logic                       m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0]     m_axis_tdata;
	logic [OUT_TUSER_W-1:0]     m_axis_tuser;

	int                         mismatches;
	int                         outstanding;

	// sender burst state and receiver stall knobs, changed per phase
	int                         burst_left = 0;
	int                         gap_max = 0;
	bit                         stall_on = 1'b0;
	logic [7:0]                 ready_pattern = 8'hFF;
	int                         ready_phase = 0;

	// box lengths as last written, used only to size random coordinates
	longint                     box_cfg[NUM_AXES];

	always #1 clk = ~clk;

	pair_min_image_distance_top u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	image_distance_checker u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.mismatches    (mismatches),
		.outstanding   (outstanding)
	);

	// receiver: always ready unless stall_on, else walks an 8-bit ready pattern, a fresh one each lap, never all zero
	always @(negedge clk) begin
		if (!stall_on) begin
			m_axis_tready <= 1'b1;
		end else begin
			m_axis_tready <= ready_pattern[ready_phase];
			if (ready_phase == 7) begin
				ready_phase = 0;
				ready_pattern = 8'($urandom) | (8'd1 << 3'($urandom_range(0, 7)));
			end else begin
				ready_phase++;
			end
		end
	end

	// watchdog: too long without any transfer on any channel ends the run
	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (s_axis_tvalid && s_axis_tready)
					|| (m_axis_tvalid && m_axis_tready) || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("FAILURE");
		$finish;
	end

	// one input transfer; a new burst may open with a gap, valid stays high inside a burst
	task automatic send_pair(input pos_t fx, input pos_t fy, input pos_t fz,
			input pos_t sx, input pos_t sy, input pos_t sz);
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
			if (gap != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {{(IN_TDATA_W - 6*POS_W){1'b0}}, sz, sy, sx, fz, fy, fx};
		forever begin
			@(posedge clk);
			if (s_axis_tready)
				break;
		end
	endtask

	// stop sending and let every result in flight come out
	task automatic drain;
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		while (outstanding != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		forever begin
			@(posedge clk);
			if (cfg_ready)
				break;
		end
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// box and reciprocal of one axis, junk above the register width to exercise masking
	task automatic set_axis(input int axis, input longint box, input longint recip);
		logic [CFG_DATA_W-1:0] word;
		word = {$urandom, $urandom};
		word[BOX_W-1:0] = box[BOX_W-1:0];
		write_reg(CFG_IDX_W'(REG_BOX_X + axis), word);
		word = {$urandom, $urandom};
		word[RECIP_W-1:0] = recip[RECIP_W-1:0];
		write_reg(CFG_IDX_W'(REG_RECIP_X + axis), word);
		box_cfg[axis] = box & BOX_MAX;
	endtask

	task automatic set_mode(input logic [MODE_W-1:0] m);
		logic [CFG_DATA_W-1:0] word;
		word = {$urandom, $urandom};
		word[MODE_W-1:0] = m;
		write_reg(REG_MODE, word);
	endtask

	// coordinate mostly within a box and a half of the origin, sometimes anywhere
	function automatic pos_t rand_coord(input int axis);
		pos_t   c;
		longint span;
		if ($urandom_range(0, 4) == 0) begin
			c = POS_W'($urandom);
		end else begin
			span = box_cfg[axis] * 3 / 2;
			if (span < 256)
				span = 256;
			if (span > SPAN_MAX)
				span = SPAN_MAX;
			c = POS_W'(longint'($urandom_range(0, 2 * span)) - span);
		end
		return c;
	endfunction

	// random geometry: mostly matched reciprocals, sometimes mismatched or odd boxes
	task automatic randomize_geometry;
		longint box;
		longint recip;
		for (int m = 0; m < NUM_AXES; m++) begin
			case ($urandom_range(0, 9))
				0:       box = BOX_MAX;
				1:       box = $urandom_range(0, FIX_ONE - 1);
				2, 3:    box = $urandom_range(FIX_ONE, BOX_MAX);
				default: box = $urandom_range(FIX_ONE, 64 * FIX_ONE);
			endcase
			if (box == 0 || $urandom_range(0, 4) == 0) begin
				recip = $urandom;
			end else begin
				recip = (64'd1 << 48) / box;
				if (recip > RECIP_MAX)
					recip = RECIP_MAX;
			end
			set_axis(m, box, recip);
		end
		case ($urandom_range(0, 7))
			0:       write_reg(REG_SQ_CUTOFF, '0);
			1:       write_reg(REG_SQ_CUTOFF, '1);
			default: write_reg(REG_SQ_CUTOFF, {$urandom, $urandom} >> $urandom_range(0, 40));
		endcase
	endtask

	initial begin : stimulus
		logic [MODE_W-1:0] m;
		for (int a = 0; a < NUM_AXES; a++)
			box_cfg[a] = FIX_ONE;

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		// reset settings, no wrap, no cutoff: zero, full-scale differences both ways
		stall_on = 1'b1;
		gap_max  = 3;
		send_pair(0, 0, 0, 0, 0, 0);
		send_pair(POS_MIN, POS_MIN, POS_MIN, POS_MAX, POS_MAX, POS_MAX);
		send_pair(POS_MAX, POS_MAX, POS_MAX, POS_MIN, POS_MIN, POS_MIN);
		send_pair(FIX_ONE, -FIX_ONE, 3, -FIX_ONE, FIX_ONE, -3);

		// box 2.0 with an exact reciprocal: half-box ties round away from zero,
		// cutoff at 1.0 squared so a distance right on it is outside
		drain;
		for (int a = 0; a < NUM_AXES; a++)
			set_axis(a, 2 * FIX_ONE, 64'h8000_0000);
		write_reg(REG_SQ_CUTOFF, 64'h1_0000_0000);
		set_mode(MODE_BOTH);
		send_pair(0, 0, 0, FIX_ONE, 0, 0);
		send_pair(0, 0, 0, -FIX_ONE, FIX_ONE / 2, 0);
		send_pair(0, 0, 0, FIX_ONE / 2, 0, 0);
		send_pair(0, 0, 0, FIX_ONE - 1, 0, 0);
		send_pair(0, 0, 0, 3 * FIX_ONE, -3 * FIX_ONE, FIX_ONE + 1);
		send_pair(POS_MIN, POS_MAX, POS_MIN, POS_MAX, POS_MIN, POS_MAX);

		// mismatched reciprocal on x pushes the fold out of range (saturates),
		// zero box on y leaves it alone, tiny box with zero reciprocal on z
		drain;
		set_axis(0, BOX_MAX, RECIP_MAX);
		set_axis(1, 0, RECIP_MAX);
		set_axis(2, 1, 0);
		set_mode(MODE_WRAP);
		send_pair(POS_MIN, POS_MIN, POS_MIN, POS_MAX, POS_MAX, POS_MAX);
		send_pair(POS_MAX, POS_MAX, POS_MAX, POS_MIN, POS_MIN, POS_MIN);
		send_pair(0, 0, 0, 5 * FIX_ONE, -7 * FIX_ONE, 9 * FIX_ONE);

		// cutoff only, at both ends of its range
		drain;
		write_reg(REG_SQ_CUTOFF, '1);
		set_mode(MODE_CUT);
		send_pair(POS_MIN, POS_MIN, POS_MIN, POS_MAX, POS_MAX, POS_MAX);
		send_pair(0, 0, 0, 0, 0, 0);
		drain;
		write_reg(REG_SQ_CUTOFF, '0);
		send_pair(0, 0, 0, 0, 0, 0);
		send_pair(0, 0, 0, 1, 0, 0);

		// random phases, each with its own geometry, mode and flow control
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			drain;
			randomize_geometry();
			m = (p < 4) ? MODE_W'(p) : MODE_W'($urandom_range(0, 3));
			set_mode(m);
			stall_on = (p % 3) != 0;
			case (p % 3)
				0:       gap_max = 0;
				1:       gap_max = 2;
				default: gap_max = 6;
			endcase
			repeat (ITEMS_PER_PHASE)
				send_pair(rand_coord(0), rand_coord(1), rand_coord(2),
					rand_coord(0), rand_coord(1), rand_coord(2));
		end

		drain;
		repeat (TAIL_CYCLES) @(negedge clk);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
